// File: design/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 fixed-point matrix inverse
// Element widths, internal datapath widths and the adjugate cofactor table.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int N_ELEM    = 9;
  localparam int QUO_BITS  = 32;

  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int CMAG_W = PROD_W;
  localparam int PART_W = 2 * ELEM_W + 1;
  localparam int TERM_W = 3 * ELEM_W + 2;
  localparam int DMAG_W = 3 * ELEM_W;
  localparam int REM_W  = DMAG_W + 1;
  localparam int NUM_W  = CMAG_W + 2 * FRAC_BITS;
  localparam int RND_W  = DMAG_W + 1 - 2 * FRAC_BITS;

  localparam int IN_W   = N_ELEM * ELEM_W;
  localparam int OUT_W  = (N_ELEM + 1) * ELEM_W;
  localparam int USER_W = 2;
  localparam int USER_SING = 0;
  localparam int USER_CLIP = 1;

  // cofactor k = m[A]*m[B] - m[C]*m[D], adjugate row-major
  localparam logic [3:0] ADJ_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] ADJ_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] ADJ_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] ADJ_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

// File: design/matrix_inverse_3x3_unit.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit: pipelined 3x3 Q16.16 matrix inverse
// Adjugate cofactors, exact determinant, then one restoring divider per
// element with one quotient bit per stage, rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one matrix per item in s_axis_tdata, nine signed
//   Q16.16 elements, m00 in the lowest bits. The master channel returns one
//   item per matrix: nine inverse elements and the determinant in
//   m_axis_tdata, with the singular and clipped flags in m_axis_tuser.
//   Throughput is one item per cycle unless the receiver stalls. Each item
//   passes through six stages of multiply, add and magnitude, one set-up
//   stage, one stage per quotient bit of the dividers, and one stage for
//   rounding and saturation.
//   The whole pipeline advances together; when the receiver holds
//   m_axis_tready low with a result waiting, every stage holds and
//   s_axis_tready drops, so no item is lost or repeated. Bubbles between
//   items are carried along as invalid stages.
//   Reset clears all valid bits; the pipeline is empty afterwards.
module matrix_inverse_3x3_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // m00 m01 m02 m10 m11 m12 m20 m21 m22, 32 bits each
  input  logic [mi3_pkg::IN_W-1:0]               s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // r00 r01 r02 r10 r11 r12 r20 r21 r22 det_out, 32 bits each
  output logic [mi3_pkg::OUT_W-1:0]              m_axis_tdata,
  // singular, clipped
  output logic [mi3_pkg::USER_W-1:0]             m_axis_tuser
);

  localparam int NE = mi3_pkg::N_ELEM;
  localparam int EW = mi3_pkg::ELEM_W;
  localparam int QB = mi3_pkg::QUO_BITS;
  localparam int FB = mi3_pkg::FRAC_BITS;
  localparam int NV = QB + 8;

  logic [NV-1:0] vld_q;
  logic          adv;

  assign adv           = !vld_q[NV-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], s_axis_tvalid};
    end
  end

  // stage 1: cofactor products
  logic signed [EW-1:0] elem [NE];
  always_comb begin
    for (int k = 0; k < NE; k++) begin
      elem[k] = s_axis_tdata[k*EW +: EW];
    end
  end

  logic signed [mi3_pkg::PROD_W-1:0] pa_q [NE];
  logic signed [mi3_pkg::PROD_W-1:0] pb_q [NE];
  logic signed [EW-1:0]              row1_q [3];
  logic signed [EW-1:0]              row2_q [3];
  logic signed [mi3_pkg::COF_W-1:0]  cof2_q [NE];
  logic signed [mi3_pkg::COF_W-1:0]  cof3_q [NE];
  logic signed [mi3_pkg::COF_W-1:0]  cof4_q [NE];
  logic signed [mi3_pkg::COF_W-1:0]  cof5_q [NE];
  logic signed [mi3_pkg::PART_W-1:0] plo_q [3];
  logic signed [mi3_pkg::PART_W-1:0] phi_q [3];
  logic signed [mi3_pkg::TERM_W-1:0] term4_q [3];
  logic signed [mi3_pkg::TERM_W-1:0] det5_q;
  logic [mi3_pkg::DMAG_W-1:0]        dmag6_q;
  logic                              dneg6_q;
  logic [mi3_pkg::CMAG_W-1:0]        cmag6_q [NE];
  logic [NE-1:0]                     cneg6_q;

  // magnitudes for stage 6
  logic [mi3_pkg::TERM_W-1:0] det_neg;
  logic [mi3_pkg::DMAG_W-1:0] dmag_d;
  logic [mi3_pkg::COF_W-1:0]  cof_neg [NE];
  logic [mi3_pkg::CMAG_W-1:0] cmag_d [NE];

  always_comb begin
    det_neg = -det5_q;
    dmag_d  = det5_q[mi3_pkg::TERM_W-1] ? det_neg[mi3_pkg::DMAG_W-1:0]
                                        : det5_q[mi3_pkg::DMAG_W-1:0];
    for (int k = 0; k < NE; k++) begin
      cof_neg[k] = -cof5_q[k];
      cmag_d[k]  = cof5_q[k][mi3_pkg::COF_W-1] ? cof_neg[k][mi3_pkg::CMAG_W-1:0]
                                               : cof5_q[k][mi3_pkg::CMAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        pa_q[k]   <= elem[mi3_pkg::ADJ_A[k]] * elem[mi3_pkg::ADJ_B[k]];
        pb_q[k]   <= elem[mi3_pkg::ADJ_C[k]] * elem[mi3_pkg::ADJ_D[k]];
        cof2_q[k] <= mi3_pkg::COF_W'(pa_q[k]) - mi3_pkg::COF_W'(pb_q[k]);
        cof3_q[k] <= cof2_q[k];
        cof4_q[k] <= cof3_q[k];
        cof5_q[k] <= cof4_q[k];
        cmag6_q[k] <= cmag_d[k];
        cneg6_q[k] <= cof5_q[k][mi3_pkg::COF_W-1];
      end
      for (int k = 0; k < 3; k++) begin
        row1_q[k]  <= elem[k];
        row2_q[k]  <= row1_q[k];
        // split the cofactor into a signed high part and an unsigned low word
        plo_q[k]   <= row2_q[k] * $signed({1'b0, cof2_q[3*k][EW-1:0]});
        phi_q[k]   <= row2_q[k] * $signed(cof2_q[3*k][mi3_pkg::COF_W-1:EW]);
        term4_q[k] <= (mi3_pkg::TERM_W'(phi_q[k]) <<< EW) + mi3_pkg::TERM_W'(plo_q[k]);
      end
      det5_q  <= term4_q[0] + term4_q[1] + term4_q[2];
      dmag6_q <= dmag_d;
      dneg6_q <= det5_q[mi3_pkg::TERM_W-1];
    end
  end

  // divider set-up and determinant rounding
  logic [mi3_pkg::NUM_W-1:0] num [NE];
  logic [mi3_pkg::REM_W-1:0] drnd;
  logic [mi3_pkg::RND_W-1:0] dm;
  logic [mi3_pkg::RND_W-1:0] dlim;
  logic [mi3_pkg::RND_W-1:0] dsel;
  logic                      dneg_eff;
  logic                      dover;
  logic [EW-1:0]             dval_d;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      num[k] = {cmag6_q[k], {(2*FB){1'b0}}};
    end
    drnd     = {1'b0, dmag6_q} + (mi3_pkg::REM_W'(1) << (2*FB - 1));
    dm       = drnd[mi3_pkg::REM_W-1:2*FB];
    dneg_eff = dneg6_q && (dm != '0);
    dlim     = dneg_eff ? (mi3_pkg::RND_W'(1) << (EW - 1))
                        : ((mi3_pkg::RND_W'(1) << (EW - 1)) - mi3_pkg::RND_W'(1));
    dover    = dm > dlim;
    dsel     = dover ? dlim : dm;
    dval_d   = dneg_eff ? -dsel[EW-1:0] : dsel[EW-1:0];
  end

  // divider pipeline: index s holds the state after s quotient bits
  logic [mi3_pkg::REM_W-1:0]  ra_q [QB+1][NE];
  logic [QB-1:0]              qa_q [QB+1][NE];
  logic [QB-1:0]              na_q [QB+1][NE];
  logic [NE-1:0]              sg_q [QB+1];
  logic [NE-1:0]              ovf_q [QB+1];
  logic [mi3_pkg::DMAG_W-1:0] dd_q [QB+1];
  logic                       dn_q [QB+1];
  logic                       sing_q [QB+1];
  logic [EW-1:0]              dval_q [QB+1];
  logic                       dclip_q [QB+1];

  logic [mi3_pkg::REM_W-1:0] ra_d [QB+1][NE];
  logic [QB-1:0]             qa_d [QB+1][NE];
  logic [QB-1:0]             na_d [QB+1][NE];
  logic [mi3_pkg::REM_W-1:0] rs;
  logic                      ge;

  always_comb begin
    for (int s = 0; s <= QB; s++) begin
      for (int k = 0; k < NE; k++) begin
        ra_d[s][k] = '0;
        qa_d[s][k] = '0;
        na_d[s][k] = '0;
      end
    end
    rs = '0;
    ge = 1'b0;
    for (int s = 0; s < QB; s++) begin
      for (int k = 0; k < NE; k++) begin
        rs = {ra_q[s][k][mi3_pkg::REM_W-2:0], na_q[s][k][QB-1]};
        ge = rs >= {1'b0, dd_q[s]};
        ra_d[s+1][k] = ge ? rs - {1'b0, dd_q[s]} : rs;
        qa_d[s+1][k] = {qa_q[s][k][QB-2:0], ge};
        na_d[s+1][k] = na_q[s][k] << 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        ra_q[0][k]  <= mi3_pkg::REM_W'(num[k][mi3_pkg::NUM_W-1:QB]);
        qa_q[0][k]  <= '0;
        na_q[0][k]  <= num[k][QB-1:0];
        sg_q[0][k]  <= cneg6_q[k];
        // quotient would need more than QB bits
        ovf_q[0][k] <= mi3_pkg::REM_W'(num[k][mi3_pkg::NUM_W-1:QB]) >= {1'b0, dmag6_q};
      end
      dd_q[0]    <= dmag6_q;
      dn_q[0]    <= dneg6_q;
      sing_q[0]  <= dmag6_q == '0;
      dval_q[0]  <= dval_d;
      dclip_q[0] <= dover;
      for (int s = 1; s <= QB; s++) begin
        for (int k = 0; k < NE; k++) begin
          ra_q[s][k] <= ra_d[s][k];
          qa_q[s][k] <= qa_d[s][k];
          na_q[s][k] <= na_d[s][k];
        end
        sg_q[s]    <= sg_q[s-1];
        ovf_q[s]   <= ovf_q[s-1];
        dd_q[s]    <= dd_q[s-1];
        dn_q[s]    <= dn_q[s-1];
        sing_q[s]  <= sing_q[s-1];
        dval_q[s]  <= dval_q[s-1];
        dclip_q[s] <= dclip_q[s-1];
      end
    end
  end

  // final rounding, sign and saturation
  logic [mi3_pkg::REM_W-1:0] r2;
  logic [QB:0]               qr;
  logic [QB:0]               qlim;
  logic [QB:0]               qsel;
  logic                      qneg;
  logic [NE-1:0]             qover;
  logic [EW-1:0]             rval [NE];
  logic [mi3_pkg::OUT_W-1:0] odata_d;
  logic [mi3_pkg::USER_W-1:0] ouser_d;

  always_comb begin
    r2   = '0;
    qr   = '0;
    qlim = '0;
    qsel = '0;
    qneg = 1'b0;
    for (int k = 0; k < NE; k++) begin
      r2       = {ra_q[QB][k][mi3_pkg::REM_W-2:0], 1'b0};
      qr       = {1'b0, qa_q[QB][k]} + (QB+1)'(r2 >= {1'b0, dd_q[QB]});
      qneg     = (sg_q[QB][k] != dn_q[QB]) && (qr != '0);
      qlim     = qneg ? ((QB+1)'(1) << (EW - 1))
                      : (((QB+1)'(1) << (EW - 1)) - (QB+1)'(1));
      qover[k] = !sing_q[QB] && (ovf_q[QB][k] || (qr > qlim));
      qsel     = (ovf_q[QB][k] || (qr > qlim)) ? qlim : qr;
      rval[k]  = sing_q[QB] ? '0 : (qneg ? -qsel[EW-1:0] : qsel[EW-1:0]);
    end
    odata_d = '0;
    for (int k = 0; k < NE; k++) begin
      odata_d[k*EW +: EW] = rval[k];
    end
    odata_d[NE*EW +: EW] = sing_q[QB] ? '0 : dval_q[QB];
    ouser_d = '0;
    ouser_d[mi3_pkg::USER_SING] = sing_q[QB];
    ouser_d[mi3_pkg::USER_CLIP] = !sing_q[QB] && ((|qover) || dclip_q[QB]);
  end

  logic [mi3_pkg::OUT_W-1:0]  odata_q;
  logic [mi3_pkg::USER_W-1:0] ouser_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      odata_q <= odata_d;
      ouser_q <= ouser_d;
    end
  end

  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = ouser_q;

endmodule

// File: tb/sv/tb_matrix_inverse_3x3_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3_unit: self-checking bench for the 3x3 matrix inverse
// Drives Q16.16 matrices with random gaps, stalls the result side at random,
// and checks every inverse, determinant and flag pair against an exact
// wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3_unit;

  localparam int QUO_BITS  = mi3_pkg::QUO_BITS;
  localparam int OUT_W     = mi3_pkg::OUT_W;
  localparam int USER_W    = mi3_pkg::USER_W;
  localparam int IN_W      = mi3_pkg::IN_W;
  localparam int N_ELEM    = mi3_pkg::N_ELEM;
  localparam int ELEM_W    = mi3_pkg::ELEM_W;
  localparam int FRAC_BITS = mi3_pkg::FRAC_BITS;
  localparam int USER_SING = mi3_pkg::USER_SING;
  localparam int USER_CLIP = mi3_pkg::USER_CLIP;
  localparam logic [3:0] ADJ_A [N_ELEM] = mi3_pkg::ADJ_A;
  localparam logic [3:0] ADJ_B [N_ELEM] = mi3_pkg::ADJ_B;
  localparam logic [3:0] ADJ_C [N_ELEM] = mi3_pkg::ADJ_C;
  localparam logic [3:0] ADJ_D [N_ELEM] = mi3_pkg::ADJ_D;

  localparam int LATENCY     = QUO_BITS + 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [OUT_W-1:0]  data;
    logic [USER_W-1:0] user;
  } inverse_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic [USER_W-1:0]  m_axis_tuser;

  inverse_t   inverse_q[$];
  int         mismatches = 0;
  int         matrices_sent = 0;
  int         results_seen = 0;
  int         singular_seen = 0;
  int         clipped_seen = 0;
  int         cycles = 0;
  int         stall_left = 0;
  bit         no_idle = 1'b0;

  matrix_inverse_3x3_unit u_top (.*);

  always #1 clk_i = ~clk_i;

  // Saturate a sign-magnitude value to a 32-bit pattern.
  function automatic logic [31:0] saturate32(input bit neg, input logic [127:0] mag,
                                             inout bit clip);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      clip = 1'b1;
      mag  = lim;
    end
    return neg ? 32'(-mag) : mag[31:0];
  endfunction

  function automatic inverse_t predict_inverse(input logic [IN_W-1:0] mat);
    logic signed [31:0]  e [N_ELEM];
    logic signed [127:0] cof [N_ELEM];
    logic signed [127:0] det;
    logic [127:0]        dmag, cmag, num, q, r;
    bit                  clip, neg;
    inverse_t            res;
    clip = 1'b0;
    res  = '0;
    for (int k = 0; k < N_ELEM; k++) e[k] = mat[k*ELEM_W +: ELEM_W];
    for (int k = 0; k < N_ELEM; k++)
      cof[k] = e[ADJ_A[k]] * e[ADJ_B[k]] - e[ADJ_C[k]] * e[ADJ_D[k]];
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    if (det == 0) begin
      res.user[USER_SING] = 1'b1;
      return res;
    end
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < N_ELEM; k++) begin
      cmag = cof[k] < 0 ? -cof[k] : cof[k];
      num  = cmag << (2 * FRAC_BITS);
      q    = num / dmag;
      r    = num % dmag;
      if ((r << 1) >= dmag) q++;
      neg  = ((cof[k] < 0) != (det < 0)) && (q != 0);
      res.data[k*ELEM_W +: ELEM_W] = saturate32(neg, q, clip);
    end
    q   = (dmag + (128'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    neg = (det < 0) && (q != 0);
    res.data[N_ELEM*ELEM_W +: ELEM_W] = saturate32(neg, q, clip);
    res.user[USER_CLIP] = clip;
    return res;
  endfunction

  // Send one matrix after a random gap; return once it is accepted.
  task automatic send_matrix(input logic [IN_W-1:0] mat);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    inverse_q.push_back(predict_inverse(mat));
    matrices_sent++;
  endtask

  function automatic logic [IN_W-1:0] pack_rows(input logic [31:0] a0, a1, a2,
                                                b0, b1, b2, c0, c1, c2);
    return {c2, c1, c0, b2, b1, b0, a2, a1, a0};
  endfunction

  function automatic logic [31:0] rand_elem(input int kind);
    case (kind)
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2:       return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] random_matrix();
    logic [IN_W-1:0] mat;
    int mode, kind;
    mode = $urandom_range(0, 9);
    kind = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 4;
    for (int k = 0; k < N_ELEM; k++) begin
      mat[k*ELEM_W +: ELEM_W] = (kind == 4) ? rand_elem($urandom_range(0, 3))
                                            : rand_elem(kind);
    end
    case (mode)
      8: mat[2*3*ELEM_W +: 3*ELEM_W] = mat[0 +: 3*ELEM_W];     // duplicate row
      9: mat[3*ELEM_W +: 3*ELEM_W]   = '0;                     // zero row
      default: ;
    endcase
    return mat;
  endfunction

  task automatic wait_drained();
    while (inverse_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] one, two, half, four, three, mn, mx;
    one = 32'h0001_0000; two = 32'h0002_0000; half = 32'h0000_8000;
    four = 32'h0004_0000; three = 32'h0003_0000;
    mn = 32'h8000_0000; mx = 32'h7FFF_FFFF;
    send_matrix(pack_rows(one, 0, 0, 0, one, 0, 0, 0, one));
    send_matrix(pack_rows(-one, 0, 0, 0, -one, 0, 0, 0, -one));
    send_matrix('0);
    send_matrix({N_ELEM{mn}});
    send_matrix({N_ELEM{mx}});
    send_matrix(pack_rows(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    send_matrix(pack_rows(mx, 0, 0, 0, mx, 0, 0, 0, mn));
    send_matrix(pack_rows(two, 0, 0, 0, half, 0, 0, 0, four));
    send_matrix(pack_rows(three, 0, 0, 0, three, 0, 0, 0, three));
    // tiny determinant: rounds to zero but the inverse saturates
    send_matrix(pack_rows(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(pack_rows(32'h100, 0, 0, 0, 32'h100, 0, 0, 0, 32'h100));
    send_matrix(pack_rows(one, two, three, one, two, three, four, half, one));
    send_matrix(pack_rows(one, two, three, four, half, one, 0, 0, 0));
    send_matrix(pack_rows(0, one, 0, one, 0, 0, 0, 0, one));
    send_matrix(pack_rows(two, one, 0, one, two, one, 0, one, two));
    send_matrix(pack_rows(mn, mx, mn, mx, mn, mx, mn, mx, mx));
    send_matrix(pack_rows(1, 2, 3, 4, 5, 6, 7, 8, 10));
    send_matrix(pack_rows(-1, 0, 0, 0, -1, 0, 0, 0, -1));
    send_matrix({N_ELEM{32'hAAAA_5555}});
    send_matrix(pack_rows(32'h5555_AAAA, 0, 0, 0, 32'hAAAA_5555, 0, 0, 0, three));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_matrix(random_matrix());
    end
    no_idle = 1'b0;
  endtask

  // Hold off the sender until the pipeline is empty, then burst back-to-back.
  task automatic test_drain_and_burst();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) send_matrix(random_matrix());
    no_idle = 1'b0;
  endtask

  // Result side: random stall per item, with stretches of no stall.
  always @(posedge clk_i) begin
    int next_stall;
    next_stall = stall_left;
    if (m_axis_tvalid && m_axis_tready) next_stall = no_idle ? 0 : $urandom_range(0, 5);
    if (next_stall > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= next_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end
  end

  always @(posedge clk_i) begin
    inverse_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{data: m_axis_tdata, user: m_axis_tuser};
      results_seen++;
      if (got.user[USER_SING]) singular_seen++;
      if (got.user[USER_CLIP]) clipped_seen++;
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = inverse_q.pop_front();
        for (int k = 0; k <= N_ELEM; k++) begin
          if (got.data[k*ELEM_W +: ELEM_W] !== want.data[k*ELEM_W +: ELEM_W]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d field %0d: expected %h, got %h", results_seen, k,
                       want.data[k*ELEM_W +: ELEM_W], got.data[k*ELEM_W +: ELEM_W]);
          end
        end
        if (got.user !== want.user) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d flags (clipped, singular): expected %b, got %b",
                     results_seen, want.user, got.user);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(330);
    test_drain_and_burst();
    test_random(330);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);
    mismatches += inverse_q.size();
    $display("%0d matrices sent, %0d results checked (%0d singular, %0d clipped)",
             matrices_sent, results_seen, singular_seen, clipped_seen);
    $display("covered extremes, tiny determinants, singular rows, gaps and stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
